// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Operation and status codes, the command broadcast along the cell chain and
// the entry word that passes between neighbor cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int KeyW = 32;
	localparam int TagW = 16;
	localparam int OccW = 5;
	localparam int InW  = 56;
	localparam int OutW = 56;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                   valid;
		logic signed [KeyW-1:0] key;
		logic [TagW-1:0]        tag;
	} entry_t;

	typedef struct packed {
		op_t                    op;
		logic                   full;
		logic signed [KeyW-1:0] key;
		logic [TagW-1:0]        tag;
	} cmd_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted list priority queue on a chain of cells
// The result word and every cell are registered at accept.
// Throughput: one word per cycle while m_tready does not stall the output.
// Reset clears the valid bits, the count and the output valid flag; stored
// keys and tags are not reset and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [1:0] operation, [33:2] key, [49:34] payload_tag, [55:50] zero
	input  logic [spq_pkg::InW-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [1:0] status, [2] out_valid, [34:3] out_key, [50:35] out_tag,
	// [55:51] occupancy
	output logic [spq_pkg::OutW-1:0] m_tdata
);
	import spq_pkg::*;

	localparam int CntW = $clog2(CAPACITY + 1);

	logic                   accept;
	op_t                    op_in;
	cmd_t                   cmd;
	logic                   full;
	logic                   empty;
	logic [CntW-1:0]        count_q;
	logic [CntW-1:0]        count_nxt;
	entry_t                 ent    [CAPACITY];
	logic                   ahead  [CAPACITY];
	logic [CAPACITY-1:0]    valid_vec;

	logic                   m_tvalid_q;
	status_t                status_q;
	logic                   out_valid_q;
	logic signed [KeyW-1:0] out_key_q;
	logic [TagW-1:0]        out_tag_q;
	logic [OccW-1:0]        occ_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op_in    = op_t'(s_tdata[1:0]);
	assign full     = (count_q >= CntW'(CAPACITY));
	assign empty    = (count_q == '0);

	always_comb begin
		cmd.op   = accept ? op_in : OP_NOP;
		cmd.full = full;
		cmd.key  = s_tdata[33:2];
		cmd.tag  = s_tdata[49:34];
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			entry_t left_ent;
			entry_t right_ent;
			logic   left_bef;

			if (gi == 0) begin : g_head
				assign left_ent = '{valid: 1'b1, key: '0, tag: '0};
				assign left_bef = 1'b1;
			end else begin : g_body
				assign left_ent = ent[gi-1];
				assign left_bef = ahead[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign right_ent = '{valid: 1'b0, key: '0, tag: '0};
			end else begin : g_mid
				assign right_ent = ent[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.head        ((gi == 0) ? 1'b1 : 1'b0),
				.left        (left_ent),
				.left_before (left_bef),
				.right       (right_ent),
				.ent         (ent[gi]),
				.ahead       (ahead[gi])
			);

			assign valid_vec[gi] = ent[gi].valid;
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		case (cmd.op)
			OP_INSERT: if (!full)  count_nxt = count_q + CntW'(1);
			OP_REMOVE: if (!empty) count_nxt = count_q - CntW'(1);
			OP_CLEAR:  count_nxt = '0;
			default:   count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result word: the head is read before the chain shifts
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
			out_key_q   <= '0;
			out_tag_q   <= '0;
			occ_q       <= OccW'(count_nxt);
			case (op_in)
				OP_INSERT: if (full) status_q <= ST_FULL;
				OP_REMOVE: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						out_valid_q <= 1'b1;
						out_key_q   <= ent[0].key;
						out_tag_q   <= ent[0].tag;
					end
				end
				default: status_q <= ST_OK;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {occ_q, out_tag_q, out_key_q, out_valid_q, status_q};

`ifndef ASSERT_OFF
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("count differs from number of valid cells");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> ent[0].valid)
		else $error("queue not empty but head cell invalid");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_in == OP_INSERT && full) |=> (count_q == $past(count_q)))
		else $error("insert into full queue changed count");

	a_remove_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_in == OP_REMOVE && !empty) |=>
		(out_valid_q && out_key_q == $past(ent[0].key)))
		else $error("remove did not report the head entry");
`endif

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on each command keeps it, takes the new entry, clears it,
// or takes the left entry (insert shift) or the right entry (remove shift).
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::cmd_t  cmd,
	input  logic           head,
	input  spq_pkg::entry_t left,
	input  logic           left_before,
	input  spq_pkg::entry_t right,
	output spq_pkg::entry_t ent,
	output logic           ahead
);
	import spq_pkg::*;

	logic                   valid_q;
	logic signed [KeyW-1:0] key_q;
	logic [TagW-1:0]        tag_q;
	entry_t                 nxt;

	assign ent = '{valid: valid_q, key: key_q, tag: tag_q};

	// an equal head stays in front of the new entry
	assign ahead = valid_q && ((key_q < cmd.key) || (head && (key_q == cmd.key)));

	always_comb begin
		nxt = ent;
		case (cmd.op)
			OP_INSERT: begin
				if (!cmd.full && !ahead) begin
					nxt.valid = valid_q | left.valid;
					if (left_before) begin
						nxt.key = cmd.key;
						nxt.tag = cmd.tag;
					end else begin
						nxt.key = left.key;
						nxt.tag = left.tag;
					end
				end
			end
			OP_REMOVE: nxt = right;
			OP_CLEAR:  nxt.valid = 1'b0;
			default:   nxt = ent;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= nxt.key;
		tag_q <= nxt.tag;
	end

endmodule
